[design/best_fit_partition_allocator_top_macros.svh]
// assertion macros for the best-fit partition allocator
// expects clk and arst_n in the scope of every use
`ifndef BEST_FIT_PARTITION_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BFPA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bfpa assertion failed");
`define BFPA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfpa implication failed");
`else
`define BFPA_ASSERT(lbl, prop)
`define BFPA_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

[design/bfpa_pkg.sv]
// shared types and constants of the best-fit partition allocator
// no dependencies
`default_nettype none
package bfpa_pkg;

	localparam int unsigned PARTITIONS_DEF = 4;
	localparam int unsigned IDX_W = 2;
	localparam int unsigned ID_W = 16;
	localparam int unsigned SIZE_W = 16;
	localparam int unsigned USED_W = 18;
	localparam int unsigned CNT_W = 3;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned SIZE_REGS = 4;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_TOTAL = 3'd0;
	localparam reg_idx_t REG_COUNT = 3'd1;
	localparam reg_idx_t REG_SIZE0 = 3'd2;
	localparam reg_idx_t REG_SIZE1 = 3'd3;
	localparam reg_idx_t REG_SIZE2 = 3'd4;
	localparam reg_idx_t REG_SIZE3 = 3'd5;

	typedef enum logic [2:0] {
		ST_ADDED      = 3'd0,
		ST_REMOVED    = 3'd1,
		ST_DUPLICATE  = 3'd2,
		ST_TOO_LARGE  = 3'd3,
		ST_ALL_FULL   = 3'd4,
		ST_FRAGMENTED = 3'd5,
		ST_ABSENT     = 3'd6
	} status_t;

	// running result of a scan as it walks the cell row
	typedef struct packed {
		logic              dup;
		logic              any_free;
		logic              found;
		logic [IDX_W-1:0]  best_idx;
		logic [SIZE_W-1:0] best_size;
		logic              hit;
		logic [IDX_W-1:0]  hit_idx;
		logic [SIZE_W-1:0] hit_size;
		logic [USED_W-1:0] used;
	} scan_tok_t;

	// update sent to one cell when a transaction completes
	typedef struct packed {
		logic alloc;
		logic evict;
	} cell_cmd_t;

endpackage
`default_nettype wire

[design/bfpa_cell.sv]
// one partition cell: holds occupancy, resident id and size, folds itself into the scan
// depends on bfpa_pkg
`default_nettype none
module bfpa_cell #(
	parameter int unsigned IDX = 0
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       active,
	input  wire logic [15:0]                part_size,
	input  wire logic [15:0]                req_id,
	input  wire logic [15:0]                req_size,
	input  wire bfpa_pkg::cell_cmd_t        cmd,
	input  wire logic                       tok_in_valid,
	input  wire bfpa_pkg::scan_tok_t        tok_in,
	output logic                            tok_valid_q,
	output bfpa_pkg::scan_tok_t             tok_q,
	output logic                            occupied
);
	import bfpa_pkg::*;

	logic              occ_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] size_q;
	logic              match;
	logic              free_here;
	logic              fits;
	scan_tok_t         tok_nxt;

	assign occupied = occ_q;

	always_comb begin
		match     = active && occ_q && (id_q == req_id);
		free_here = active && !occ_q;
		fits      = free_here && (part_size >= req_size)
			&& (!tok_in.found || (part_size < tok_in.best_size));
		tok_nxt = tok_in;
		if (match) begin
			tok_nxt.dup = 1'b1;
		end
		if (free_here) begin
			tok_nxt.any_free = 1'b1;
		end
		// strict compare keeps the lower index on equal sizes
		if (fits) begin
			tok_nxt.found     = 1'b1;
			tok_nxt.best_idx  = IDX_W'(IDX);
			tok_nxt.best_size = part_size;
		end
		if (match && !tok_in.hit) begin
			tok_nxt.hit      = 1'b1;
			tok_nxt.hit_idx  = IDX_W'(IDX);
			tok_nxt.hit_size = size_q;
		end
		if (active && occ_q) begin
			tok_nxt.used = tok_in.used + USED_W'(size_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= 1'b0;
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in_valid;
			if (cmd.alloc) begin
				occ_q <= 1'b1;
			end else if (cmd.evict) begin
				occ_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (cmd.alloc) begin
			id_q   <= req_id;
			size_q <= req_size;
		end
	end

endmodule
`default_nettype wire

[design/best_fit_partition_allocator_top.sv]
// Best-fit fixed-partition allocator. A request walks a row of PARTITIONS cells, one cell per
// clock, gathering duplicate-id, best-fit and resident-size information; the scan result is
// then registered, and once the output register is free or being read the status is decided,
// the chosen cell is updated and the output register is loaded. A request is not accepted
// until the result of the one before it is loaded. in_ready rises as soon as the result is
// loaded, so a new request is taken while the result still waits.
// Configuration goes through the APB port at byte address 4*index and must only be written
// while no request is in flight.
`default_nettype none
`include "best_fit_partition_allocator_top_macros.svh"
module best_fit_partition_allocator_top #(
	parameter int unsigned PARTITIONS = bfpa_pkg::PARTITIONS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [bfpa_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bfpa_pkg::DATA_W-1:0] pwdata,
	output logic      [bfpa_pkg::DATA_W-1:0] prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        req_type,
	input  wire logic [15:0]                 process_id,
	input  wire logic [15:0]                 proc_size,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output bfpa_pkg::status_t                status,
	output logic [1:0]                       partition_index,
	output logic [15:0]                      free_space
);
	import bfpa_pkg::*;

	// configuration
	logic [SIZE_W-1:0] total_q;
	logic [CNT_W-1:0]  count_q;
	logic [SIZE_W-1:0] size_q [SIZE_REGS];
	reg_idx_t          widx;
	reg_idx_t          ridx;
	logic              cfg_wr;

	// request and scan
	logic              busy_q;
	logic              start_q;
	logic              type_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] psize_q;
	logic [CNT_W-1:0]  n_active;
	logic [PARTITIONS-1:0] active;
	logic [PARTITIONS:0]   vld;
	scan_tok_t         tok [PARTITIONS+1];
	cell_cmd_t         cmd [PARTITIONS];
	logic [PARTITIONS-1:0] occ_vec;
	logic [PARTITIONS-1:0] alloc_vec;
	logic [PARTITIONS-1:0] evict_vec;
	logic              fin_v_q;
	scan_tok_t         fin_q;
	logic              commit;

	// result
	status_t           res_status;
	logic [IDX_W-1:0]  res_idx;
	logic [USED_W-1:0] used_new;
	logic [SIZE_W-1:0] free_before;
	logic [SIZE_W-1:0] free_after;
	logic              do_alloc;
	logic              do_evict;
	logic              out_valid_q;
	status_t           status_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SIZE_W-1:0] free_q;

	assign pready = 1'b1;
	assign widx   = paddr[ADDR_W-1:2];
	assign ridx   = paddr[ADDR_W-1:2];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= CNT_W'(4);
			for (int k = 0; k < SIZE_REGS; k++) begin
				size_q[k] <= '0;
			end
		end else if (cfg_wr) begin
			unique case (widx) inside
				REG_TOTAL: total_q <= pwdata[SIZE_W-1:0];
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				[REG_SIZE0:REG_SIZE3]: size_q[IDX_W'(widx - REG_SIZE0)] <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx) inside
			REG_TOTAL: prdata = DATA_W'(total_q);
			REG_COUNT: prdata = DATA_W'(count_q);
			[REG_SIZE0:REG_SIZE3]: prdata = DATA_W'(size_q[IDX_W'(ridx - REG_SIZE0)]);
			default:   prdata = '0;
		endcase
	end

	// active partition count, clamped to 1..PARTITIONS
	always_comb begin
		if (count_q == '0) begin
			n_active = CNT_W'(1);
		end else if (count_q > CNT_W'(PARTITIONS)) begin
			n_active = CNT_W'(PARTITIONS);
		end else begin
			n_active = count_q;
		end
	end

	assign in_ready = !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			start_q <= 1'b0;
			fin_v_q <= 1'b0;
		end else begin
			start_q <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (vld[PARTITIONS]) begin
				fin_v_q <= 1'b1;
			end else if (commit) begin
				fin_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			type_q  <= req_type;
			id_q    <= process_id;
			psize_q <= proc_size;
		end
		if (vld[PARTITIONS]) begin
			fin_q <= tok[PARTITIONS];
		end
	end

	assign vld[0] = start_q;
	assign tok[0] = '0;

	for (genvar i = 0; i < PARTITIONS; i++) begin : g_cell
		assign active[i] = CNT_W'(i) < n_active;
		assign cmd[i].alloc = commit && do_alloc && (fin_q.best_idx == IDX_W'(i));
		assign cmd[i].evict = commit && do_evict && (fin_q.hit_idx == IDX_W'(i));
		assign alloc_vec[i] = cmd[i].alloc;
		assign evict_vec[i] = cmd[i].evict;

		bfpa_cell #(
			.IDX(i)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.active       (active[i]),
			.part_size    (size_q[i]),
			.req_id       (id_q),
			.req_size     (psize_q),
			.cmd          (cmd[i]),
			.tok_in_valid (vld[i]),
			.tok_in       (tok[i]),
			.tok_valid_q  (vld[i+1]),
			.tok_q        (tok[i+1]),
			.occupied     (occ_vec[i])
		);
	end

	assign commit = fin_v_q && (!out_valid_q || out_ready);

	always_comb begin
		do_alloc   = 1'b0;
		do_evict   = 1'b0;
		res_idx    = '0;
		used_new   = fin_q.used;
		free_before = (fin_q.used >= USED_W'(total_q)) ? '0
			: SIZE_W'(USED_W'(total_q) - fin_q.used);
		if (type_q == REQ_INSERT) begin
			if (fin_q.dup) begin
				res_status = ST_DUPLICATE;
			end else if (fin_q.found) begin
				res_status = ST_ADDED;
				do_alloc   = 1'b1;
				res_idx    = fin_q.best_idx;
				used_new   = fin_q.used + USED_W'(psize_q);
			end else if (fin_q.any_free) begin
				res_status = ST_TOO_LARGE;
			end else if (free_before >= psize_q) begin
				res_status = ST_FRAGMENTED;
			end else begin
				res_status = ST_ALL_FULL;
			end
		end else begin
			if (fin_q.hit) begin
				res_status = ST_REMOVED;
				do_evict   = 1'b1;
				res_idx    = fin_q.hit_idx;
				used_new   = fin_q.used - USED_W'(fin_q.hit_size);
			end else begin
				res_status = ST_ABSENT;
			end
		end
		free_after = (used_new >= USED_W'(total_q)) ? '0
			: SIZE_W'(USED_W'(total_q) - used_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= res_status;
			idx_q    <= res_idx;
			free_q   <= free_after;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign partition_index = idx_q;
	assign free_space      = free_q;

	`BFPA_ASSERT(a_one_alloc, $onehot0(alloc_vec))
	`BFPA_ASSERT(a_one_evict, $onehot0(evict_vec))
	`BFPA_ASSERT(a_alloc_free_cell, (alloc_vec & occ_vec) == '0)
	`BFPA_ASSERT_IMP(a_evict_held_cell, evict_vec != '0, (evict_vec & ~occ_vec) == '0)
	`BFPA_ASSERT_IMP(a_err_index_zero,
		out_valid && status != ST_ADDED && status != ST_REMOVED, partition_index == '0)

endmodule
`default_nettype wire

[sim/testbench.sv]
// self-checking testbench for the best-fit partition allocator top level
// needs bfpa_pkg and the allocator rtl; a ledger class predicts every reply
`timescale 1ns / 100ps

import bfpa_pkg::*;

class partition_ledger;
	typedef struct {
		status_t     status;
		logic [1:0]  index;
		logic [15:0] free;
	} reply_t;

	reply_t      pending_replies[$];
	logic [15:0] total_mem;
	logic [2:0]  part_count;
	logic [15:0] part_size [PARTITIONS_DEF];
	bit          occupied [PARTITIONS_DEF];
	logic [15:0] res_id [PARTITIONS_DEF];
	logic [15:0] res_size [PARTITIONS_DEF];
	int          mismatches;
	int          requests;
	int          checked;
	int          outcomes [7];

	function new();
		total_mem = 16'd0;
		part_count = 3'd4;
		mismatches = 0;
		requests = 0;
		checked = 0;
		for (int i = 0; i < PARTITIONS_DEF; i++) begin
			part_size[i] = 16'd0;
			occupied[i] = 1'b0;
			res_id[i] = 16'd0;
			res_size[i] = 16'd0;
		end
		for (int i = 0; i < 7; i++)
			outcomes[i] = 0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [31:0] value);
		case (idx)
			REG_TOTAL: total_mem = value[15:0];
			REG_COUNT: part_count = value[2:0];
			REG_SIZE0: part_size[0] = value[15:0];
			REG_SIZE1: part_size[1] = value[15:0];
			REG_SIZE2: part_size[2] = value[15:0];
			REG_SIZE3: part_size[3] = value[15:0];
			default: ;
		endcase
	endfunction

	// count register is clamped to 1..PARTITIONS
	function int active_parts();
		int n;
		n = part_count;
		if (n < 1)
			n = 1;
		if (n > PARTITIONS_DEF)
			n = PARTITIONS_DEF;
		return n;
	endfunction

	function logic [15:0] free_now();
		int used;
		int n;
		used = 0;
		n = active_parts();
		for (int i = 0; i < n; i++)
			if (occupied[i])
				used += res_size[i];
		if (used >= total_mem)
			return 16'd0;
		return 16'(total_mem - used);
	endfunction

	function void take_request(logic kind, logic [15:0] pid, logic [15:0] psize);
		reply_t r;
		int     n;
		bit     dup;
		bit     any_free;
		bit     found;
		int     best;
		n = active_parts();
		dup = 1'b0;
		any_free = 1'b0;
		found = 1'b0;
		best = 0;
		r.index = 2'd0;
		requests++;
		if (kind == REQ_INSERT) begin
			for (int i = 0; i < n; i++)
				if (occupied[i] && res_id[i] == pid)
					dup = 1'b1;
			if (dup) begin
				r.status = ST_DUPLICATE;
			end else begin
				for (int i = 0; i < n; i++) begin
					if (!occupied[i]) begin
						any_free = 1'b1;
						if (part_size[i] >= psize && (!found || part_size[i] < part_size[best])) begin
							found = 1'b1;
							best = i;
						end
					end
				end
				if (found) begin
					occupied[best] = 1'b1;
					res_id[best] = pid;
					res_size[best] = psize;
					r.status = ST_ADDED;
					r.index = 2'(best);
				end else if (any_free) begin
					r.status = ST_TOO_LARGE;
				end else if (free_now() >= psize) begin
					r.status = ST_FRAGMENTED;
				end else begin
					r.status = ST_ALL_FULL;
				end
			end
		end else begin
			r.status = ST_ABSENT;
			for (int i = 0; i < n; i++) begin
				if (occupied[i] && res_id[i] == pid) begin
					occupied[i] = 1'b0;
					r.status = ST_REMOVED;
					r.index = 2'(i);
					break;
				end
			end
		end
		r.free = free_now();
		pending_replies.push_back(r);
	endfunction

	function void flag(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", what);
	endfunction

	function void match_reply(logic [2:0] st, logic [1:0] idx, logic [15:0] fs);
		reply_t e;
		if (pending_replies.size() == 0) begin
			flag($sformatf("unrequested reply: status %0d index %0d free %0d", st, idx, fs));
			return;
		end
		e = pending_replies.pop_front();
		checked++;
		outcomes[int'(e.status)]++;
		if (st !== e.status || idx !== e.index || fs !== e.free)
			flag($sformatf("reply %0d: expected status %0d index %0d free %0d, got %0d %0d %0d",
				checked, e.status, e.index, e.free, st, idx, fs));
	endfunction
endclass

module testbench;
	localparam reg_idx_t REG_UNUSED_LO = 3'd6;
	localparam reg_idx_t REG_UNUSED_HI = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                req_type = REQ_INSERT;
	logic [15:0]         process_id = 16'd0;
	logic [15:0]         proc_size = 16'd0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	status_t             status;
	logic [1:0]          partition_index;
	logic [15:0]         free_space;

	partition_ledger     ledger = new();
	bit                  tx_steady = 1'b0;
	bit                  rx_steady = 1'b0;
	logic [15:0]         cfg_total;
	logic [15:0]         cfg_size [PARTITIONS_DEF];
	int                  settings = 0;

	best_fit_partition_allocator_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.process_id(process_id),
		.proc_size(proc_size),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.partition_index(partition_index),
		.free_space(free_space)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		ledger.write_reg(idx, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// upper bits of each write carry junk that the block must drop
	task automatic configure(input logic [15:0] tot, input logic [2:0] cnt,
			input logic [15:0] s0, input logic [15:0] s1,
			input logic [15:0] s2, input logic [15:0] s3);
		apb_write(REG_TOTAL, {16'($urandom()), tot});
		apb_write(REG_COUNT, {29'($urandom()), cnt});
		apb_write(REG_SIZE0, {16'($urandom()), s0});
		apb_write(REG_SIZE1, {16'($urandom()), s1});
		apb_write(REG_SIZE2, {16'($urandom()), s2});
		apb_write(REG_SIZE3, {16'($urandom()), s3});
		cfg_total = tot;
		cfg_size[0] = s0;
		cfg_size[1] = s1;
		cfg_size[2] = s2;
		cfg_size[3] = s3;
		settings++;
	endtask

	task automatic send_request(input logic kind, input logic [15:0] pid, input logic [15:0] psize);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		process_id <= pid;
		proc_size <= psize;
		do @(posedge clk); while (in_ready !== 1'b1);
		ledger.take_request(kind, pid, psize);
	endtask

	// drain all replies, then give the scan pipeline time to go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending_replies.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = rx_steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			ledger.match_reply(status, partition_index, free_space);
		end
	end

	initial begin
		logic [15:0] pool [6];
		logic [15:0] tot;
		logic [2:0]  cnt;
		logic [15:0] sz [4];
		logic        kind;
		logic [15:0] pid;
		logic [15:0] psize;
		int          mode;
		int          v;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// tie between two 300 KB partitions, exact fits, fragmentation and full
		configure(16'd1000, 3'd4, 16'd100, 16'd300, 16'd200, 16'd300);
		apb_write(REG_UNUSED_LO, $urandom());
		apb_write(REG_UNUSED_HI, $urandom());
		send_request(REQ_INSERT, 16'd1, 16'd250);
		send_request(REQ_INSERT, 16'd1, 16'd10);
		send_request(REQ_INSERT, 16'd2, 16'd400);
		send_request(REQ_INSERT, 16'd3, 16'd0);
		send_request(REQ_INSERT, 16'd4, 16'd200);
		send_request(REQ_INSERT, 16'd5, 16'd300);
		send_request(REQ_INSERT, 16'd6, 16'd200);
		send_request(REQ_INSERT, 16'd7, 16'd300);
		send_request(REQ_REMOVE, 16'd9, 16'd0);
		send_request(REQ_REMOVE, 16'd1, 16'hFFFF);
		send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF);
		send_request(REQ_INSERT, 16'hFFFF, 16'd300);
		send_request(REQ_REMOVE, 16'd3, 16'd0);
		send_request(REQ_REMOVE, 16'hFFFF, 16'd0);
		settle();

		// count of zero acts as one; residents of partitions 2 and 3 go hidden
		configure(16'd10, 3'd0, 16'hFFFF, 16'd7, 16'd7, 16'd7);
		send_request(REQ_REMOVE, 16'd4, 16'd0);
		send_request(REQ_INSERT, 16'd0, 16'hFFFF);
		send_request(REQ_INSERT, 16'd1, 16'd1);
		send_request(REQ_INSERT, 16'd2, 16'd0);
		send_request(REQ_INSERT, 16'd0, 16'd3);
		send_request(REQ_REMOVE, 16'd0, 16'd0);
		settle();

		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0) begin
				tot = 16'hFFFF;
				cnt = 3'd7;
				for (int i = 0; i < 4; i++)
					sz[i] = 16'hFFFF;
			end else if (ph == 1) begin
				tot = 16'd0;
				cnt = 3'd1;
				for (int i = 0; i < 4; i++)
					sz[i] = 16'd0;
			end else begin
				mode = $urandom_range(0, 7);
				tot = (mode == 0) ? 16'd0 : (mode == 1) ? 16'hFFFF : 16'($urandom_range(0, 3000));
				cnt = $urandom_range(0, 1) ? 3'd4 : 3'($urandom_range(0, 7));
				for (int i = 0; i < 4; i++) begin
					mode = $urandom_range(0, 7);
					sz[i] = (mode == 0) ? 16'd0 : (mode == 1) ? 16'hFFFF : 16'($urandom_range(0, 1000));
				end
			end
			configure(tot, cnt, sz[0], sz[1], sz[2], sz[3]);
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 6; i++)
				pool[i] = 16'($urandom());

			repeat (170) begin
				if ($urandom_range(0, 99) < 8) begin
					kind = 1'($urandom());
					pid = 16'($urandom());
					psize = 16'($urandom());
				end else begin
					kind = ($urandom_range(0, 99) < 55) ? REQ_INSERT : REQ_REMOVE;
					pid = pool[$urandom_range(0, 5)];
					mode = $urandom_range(0, 9);
					// sizes cluster around partition edges to hit exact and near fits
					if (mode <= 5) begin
						v = int'(cfg_size[$urandom_range(0, 3)]) + $urandom_range(0, 3) - 2;
						if (v < 0)
							v = 0;
						if (v > 65535)
							v = 65535;
						psize = 16'(v);
					end else if (mode <= 7) begin
						psize = 16'($urandom_range(0, cfg_total));
					end else if (mode == 8) begin
						psize = 16'd0;
					end else begin
						psize = 16'($urandom());
					end
				end
				send_request(kind, pid, psize);
			end
			settle();
		end

		$display("%0d requests over %0d register settings, %0d replies checked",
			ledger.requests, settings, ledger.checked);
		$display({"outcomes: added %0d removed %0d duplicate %0d too large %0d",
			" full %0d fragmented %0d absent %0d"},
			ledger.outcomes[ST_ADDED], ledger.outcomes[ST_REMOVED],
			ledger.outcomes[ST_DUPLICATE], ledger.outcomes[ST_TOO_LARGE],
			ledger.outcomes[ST_ALL_FULL], ledger.outcomes[ST_FRAGMENTED],
			ledger.outcomes[ST_ABSENT]);
		if (ledger.mismatches == 0 && ledger.pending_replies.size() == 0) begin
			$display("best_fit_partition_allocator_top: match");
		end else begin
			$display("%0d mismatches", ledger.mismatches);
			$display("best_fit_partition_allocator_top: mismatch");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d replies outstanding", ledger.pending_replies.size());
		$display("best_fit_partition_allocator_top: mismatch");
		$finish;
	end

endmodule
